FILE: hdl/swlfp_pkg.sv
// Package for the sync-word frame parser: sizes, frame offsets, mode codes and the
// command word that travels from the front end through the queue to the back end.
// No dependencies.
`default_nettype none

package swlfp_pkg;

  localparam int unsigned BUF_DEPTH  = 400;
  localparam int unsigned DIST_BYTES = 320;
  localparam int unsigned BUF_AW     = $clog2(BUF_DEPTH);
  localparam int unsigned DIST_AW    = $clog2(DIST_BYTES);
  localparam int unsigned RIDX_W     = 9;

  localparam int unsigned HDR_LEN    = 28;
  localparam int unsigned SYNC_LEN   = 4;
  localparam int unsigned RESYNC_IDX = 4;
  localparam int unsigned DIST_FIRST = 14;
  localparam int unsigned DIST_AT    = 335;
  localparam int unsigned COEF_AT    = 29;
  localparam int unsigned RES_AT     = 14;
  localparam int unsigned COEF_FIRST = 10;
  localparam int unsigned COEF_NUM   = 4;
  localparam int unsigned PCOUNT_AT  = 26;
  localparam int unsigned RES_W_AT   = 10;
  localparam int unsigned RES_H_AT   = 12;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] MODE_DIST = 8'h02;
  localparam logic [7:0] MODE_COEF = 8'h12;
  localparam logic [7:0] MODE_RES  = 8'h15;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              is_read;
    logic              read_ok;
    logic [7:0]        rx_byte;
    logic [RIDX_W-1:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/swlfp_front.sv
// Front end: accepts input words, classifies them as receive or read and checks the
// read range, then pushes a command word into the queue. Depends on swlfp_pkg.
`default_nettype none

module swlfp_front
  import swlfp_pkg::*;
(
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [RIDX_W-1:0] read_index_i,
  input  wire q_stat_t           q_stat_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    cmd_o.is_read    = (operation_i == OP_READ);
    cmd_o.read_ok    = (read_index_i < RIDX_W'(DIST_BYTES));
    cmd_o.rx_byte    = rx_byte_i;
    cmd_o.read_index = read_index_i;
  end

endmodule

`default_nettype wire

FILE: hdl/swlfp_queue.sv
// Short command queue between the front end and the back end.
// Depends on swlfp_pkg for the command word and the queue depth.
`default_nettype none

module swlfp_queue
  import swlfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output q_stat_t   stat_o
);

  cmd_t             entry_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, wptr_d;
  logic [QAW-1:0]   rptr_q, rptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + QAW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + QAW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign data_o       = entry_q[rptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCW'(QDEPTH));

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full)) else $error("Queue pushed while full.");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty)) else $error("Queue popped while empty.");
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + QCW'(1)))
    else $error("Queue count did not follow a push.");
`endif

endmodule

`default_nettype wire

FILE: hdl/swlfp_back.sv
// Back end: executes queued commands against the frame buffer, the distance store and
// the parameter registers, and holds the result word. Depends on swlfp_pkg.
`default_nettype none

module swlfp_back
  import swlfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        cmd_valid_i,
  input  wire cmd_t        cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       read_byte_o,
  output logic             distance_captured_o,
  output logic [31:0]      coef_zero_o,
  output logic [31:0]      coef_one_o,
  output logic [31:0]      coef_two_o,
  output logic [31:0]      coef_three_o,
  output logic [15:0]      point_count_o,
  output logic [15:0]      image_width_o,
  output logic [15:0]      image_height_o,
  output logic             params_ready_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_COPY_END
  } state_e;

  state_e              state_q, state_d;
  logic [BUF_AW-1:0]   wr_idx_q, wr_idx_d;
  logic [2:0]          run_q, run_d;
  logic [7:0]          hdr_q [HDR_LEN];
  logic [7:0]          hdr_d [HDR_LEN];
  logic [DIST_AW-1:0]  cp_q, cp_d;
  logic                pend_q;
  logic [DIST_AW-1:0]  pend_idx_q;
  logic                dist_ok_q, dist_ok_d;
  logic [7:0]          mode_q, mode_d;
  logic [31:0]         coef_q [COEF_NUM];
  logic [31:0]         coef_d [COEF_NUM];
  logic [15:0]         pcount_q, pcount_d;
  logic [15:0]         width_q, width_d;
  logic [15:0]         height_q, height_d;
  logic                ready_q, ready_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_rd_q, out_rd_d;
  logic                out_cap_q, out_cap_d;

  logic [7:0]          buf_mem [BUF_DEPTH];
  logic [7:0]          buf_rd_q;
  logic [7:0]          dist_mem [DIST_BYTES];
  logic [7:0]          dist_rd_q;
  logic                buf_we, buf_re, dist_re;
  logic [BUF_AW-1:0]   buf_raddr;

  logic [BUF_AW-1:0]   widx, idx_nx;
  logic [2:0]          run_inc, run_nx;
  logic [7:0]          hdr_nx [HDR_LEN];
  logic [31:0]         coef_nx [COEF_NUM];
  logic                synced;

  always_comb begin
    widx = (wr_idx_q == BUF_AW'(BUF_DEPTH - 1)) ? '0 : wr_idx_q;
    hdr_nx = hdr_q;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (widx == BUF_AW'(i)) begin
        hdr_nx[i] = cmd_i.rx_byte;
      end
    end
    run_inc = (cmd_i.rx_byte == SYNC_BYTE) ? run_q + 3'd1 : 3'd0;
    run_nx  = run_inc;
    idx_nx  = widx + BUF_AW'(1);
    if (run_inc == 3'(SYNC_LEN)) begin
      run_nx = 3'd0;
      idx_nx = BUF_AW'(RESYNC_IDX);
      for (int i = 0; i < SYNC_LEN; i++) begin
        hdr_nx[i] = SYNC_BYTE;
      end
    end
    synced = 1'b1;
    for (int i = 0; i < SYNC_LEN; i++) begin
      if (hdr_nx[i] != SYNC_BYTE) begin
        synced = 1'b0;
      end
    end
    for (int k = 0; k < COEF_NUM; k++) begin
      coef_nx[k] = {hdr_nx[COEF_FIRST + 4 * k + 3], hdr_nx[COEF_FIRST + 4 * k + 2],
                    hdr_nx[COEF_FIRST + 4 * k + 1], hdr_nx[COEF_FIRST + 4 * k]};
    end
  end

  assign buf_raddr = BUF_AW'(DIST_FIRST) + BUF_AW'(cp_q);

  always_comb begin
    state_d     = state_q;
    wr_idx_d    = wr_idx_q;
    run_d       = run_q;
    hdr_d       = hdr_q;
    cp_d        = cp_q;
    dist_ok_d   = dist_ok_q;
    mode_d      = cfg_we_i ? cfg_wdata_i : mode_q;
    coef_d      = coef_q;
    pcount_d    = pcount_q;
    width_d     = width_q;
    height_d    = height_q;
    ready_d     = ready_q;
    out_valid_d = out_valid_q;
    out_rd_d    = out_rd_q;
    out_cap_d   = out_cap_q;
    cmd_pop_o   = 1'b0;
    buf_we      = 1'b0;
    buf_re      = 1'b0;
    dist_re     = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          out_rd_d  = 8'd0;
          out_cap_d = 1'b0;
          if (cmd_i.is_read) begin
            if (cmd_i.read_ok && dist_ok_q) begin
              dist_re = 1'b1;
              state_d = S_READ;
            end else begin
              out_valid_d = 1'b1;
            end
          end else begin
            buf_we      = 1'b1;
            hdr_d       = hdr_nx;
            wr_idx_d    = idx_nx;
            run_d       = run_nx;
            out_valid_d = 1'b1;
            if (synced && mode_q == MODE_DIST && idx_nx == BUF_AW'(DIST_AT)) begin
              out_valid_d = 1'b0;
              cp_d        = '0;
              state_d     = S_COPY;
            end else if (synced && mode_q == MODE_COEF && idx_nx == BUF_AW'(COEF_AT)) begin
              coef_d   = coef_nx;
              pcount_d = {hdr_nx[PCOUNT_AT + 1], hdr_nx[PCOUNT_AT]};
            end else if (synced && mode_q == MODE_RES && idx_nx == BUF_AW'(RES_AT)) begin
              width_d  = {hdr_nx[RES_W_AT + 1], hdr_nx[RES_W_AT]};
              height_d = {hdr_nx[RES_H_AT + 1], hdr_nx[RES_H_AT]};
              ready_d  = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
        out_rd_d    = dist_rd_q;
        out_cap_d   = 1'b0;
        state_d     = S_IDLE;
      end
      S_COPY: begin
        buf_re = 1'b1;
        cp_d   = cp_q + DIST_AW'(1);
        if (cp_q == DIST_AW'(DIST_BYTES - 1)) begin
          state_d = S_COPY_END;
        end
      end
      S_COPY_END: begin
        out_valid_d = 1'b1;
        out_rd_d    = 8'd0;
        out_cap_d   = 1'b1;
        dist_ok_d   = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_idx_q    <= '0;
      run_q       <= '0;
      hdr_q       <= '{default: '0};
      cp_q        <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      dist_ok_q   <= 1'b0;
      mode_q      <= '0;
      coef_q      <= '{default: '0};
      pcount_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_rd_q    <= '0;
      out_cap_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      run_q       <= run_d;
      hdr_q       <= hdr_d;
      cp_q        <= cp_d;
      pend_q      <= (state_q == S_COPY);
      pend_idx_q  <= cp_q;
      dist_ok_q   <= dist_ok_d;
      mode_q      <= mode_d;
      coef_q      <= coef_d;
      pcount_q    <= pcount_d;
      width_q     <= width_d;
      height_q    <= height_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      out_rd_q    <= out_rd_d;
      out_cap_q   <= out_cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[widx] <= cmd_i.rx_byte;
    end
    if (buf_re) begin
      buf_rd_q <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      dist_mem[pend_idx_q] <= buf_rd_q;
    end
    if (dist_re) begin
      dist_rd_q <= dist_mem[cmd_i.read_index[DIST_AW-1:0]];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_byte_o         = out_rd_q;
  assign distance_captured_o = out_cap_q;
  assign coef_zero_o         = coef_q[0];
  assign coef_one_o          = coef_q[1];
  assign coef_two_o          = coef_q[2];
  assign coef_three_o        = coef_q[3];
  assign point_count_o       = pcount_q;
  assign image_width_o       = width_q;
  assign image_height_o      = height_q;
  assign params_ready_o      = ready_q;

`ifndef SYNTHESIS
  a_index_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= BUF_AW'(BUF_DEPTH - 1)) else $error("Write index beyond the buffer.");
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (!out_valid_q && state_q == S_IDLE))
    else $error("Command taken while a result is pending.");
  a_copy_ends_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY_END) |=> (out_valid_q && out_cap_q && dist_ok_q))
    else $error("Copy finished without a capture result.");
`endif

endmodule

`default_nettype wire

FILE: hdl/sync_word_lidar_frame_parser_unit.sv
// Top level of the sync-word frame parser: front end, command queue and back end.
// Depends on swlfp_pkg, swlfp_front, swlfp_queue and swlfp_back.
//
// Received bytes are buffered in a frame buffer, four 0xAA bytes in a row resynchronize
// the write index to 4, and depending on the command mode a complete frame updates the
// distance store, the four coefficients with the point count, or the image size with the
// ready flag. Input words enter a two-word queue and are executed one at a time by the
// back end, which holds each result until it is taken. A receive word's result goes
// through the result register; a read word goes through the registered read port of the
// distance store and then the result register. The byte that completes a distance frame
// starts a copy of the 320 bytes from the frame buffer memory into the distance store
// through their single read and write ports, after which the result is posted; the queue
// keeps accepting words meanwhile until it is full. Reads before the first capture return
// zero; no clearing pass runs after reset.
`default_nettype none

module sync_word_lidar_frame_parser_unit
  import swlfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [RIDX_W-1:0] read_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             read_byte_o,
  output logic                   distance_captured_o,
  output logic [31:0]            coef_zero_o,
  output logic [31:0]            coef_one_o,
  output logic [31:0]            coef_two_o,
  output logic [31:0]            coef_three_o,
  output logic [15:0]            point_count_o,
  output logic [15:0]            image_width_o,
  output logic [15:0]            image_height_o,
  output logic                   params_ready_o
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    cmd_in;
  cmd_t    cmd_out;

  swlfp_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  swlfp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .pop_i  (pop),
    .data_o (cmd_out),
    .stat_o (q_stat)
  );

  swlfp_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .cmd_valid_i         (!q_stat.empty),
    .cmd_i               (cmd_out),
    .cmd_pop_o           (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .read_byte_o         (read_byte_o),
    .distance_captured_o (distance_captured_o),
    .coef_zero_o         (coef_zero_o),
    .coef_one_o          (coef_one_o),
    .coef_two_o          (coef_two_o),
    .coef_three_o        (coef_three_o),
    .point_count_o       (point_count_o),
    .image_width_o       (image_width_o),
    .image_height_o      (image_height_o),
    .params_ready_o      (params_ready_o)
  );

endmodule

`default_nettype wire

FILE: test/sync_word_lidar_frame_parser_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sync_word_lidar_frame_parser_unit: a scoreboard class predicts
// every result from the accepted words, and plain tasks drive frames, noise and reads.
// Depends on swlfp_pkg and the parser RTL.

module sync_word_lidar_frame_parser_unit_tb;
  import swlfp_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1100;
  localparam int unsigned HOLD_AFTER   = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 350;
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [7:0]  FILLER_BYTE  = 8'h55;

  typedef struct packed {
    logic [7:0]       read_byte;
    logic             dist_done;
    logic [3:0][31:0] coef;
    logic [15:0]      points;
    logic [15:0]      width;
    logic [15:0]      height;
    logic             params_ok;
  } parse_result_t;

  class frame_scoreboard;
    logic [7:0]       frame_mem [BUF_DEPTH];
    logic [7:0]       dist_mem [DIST_BYTES];
    int unsigned      wr_ptr;
    int unsigned      sync_count;
    logic [3:0][31:0] coef;
    logic [15:0]      points;
    logic [15:0]      width;
    logic [15:0]      height;
    logic             params_ok;
    logic [7:0]       mode;
    parse_result_t    results_q [$];
    int unsigned      words, reads, results, mismatches;
    int unsigned      dist_caps, coef_caps, res_caps, wraps, resyncs, mode_writes;

    function new();
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      foreach (dist_mem[i]) dist_mem[i] = 8'h00;
      wr_ptr = 0;
      sync_count = 0;
      coef = '0;
      points = '0;
      width = '0;
      height = '0;
      params_ok = 1'b0;
      mode = '0;
    endfunction

    function void set_mode(logic [7:0] m);
      mode = m;
      mode_writes++;
    endfunction

    function int unsigned pending();
      return results_q.size();
    endfunction

    function bit header_synced();
      for (int i = 0; i < SYNC_LEN; i++) begin
        if (frame_mem[i] != SYNC_BYTE) return 1'b0;
      end
      return 1'b1;
    endfunction

    function logic [31:0] le_word(int unsigned at);
      return {frame_mem[at + 3], frame_mem[at + 2], frame_mem[at + 1], frame_mem[at]};
    endfunction

    function logic [15:0] le_half(int unsigned at);
      return {frame_mem[at + 1], frame_mem[at]};
    endfunction

    function void note_word(logic op, logic [7:0] b, logic [RIDX_W-1:0] ridx);
      parse_result_t r;
      r = '0;
      words++;
      if (op == OP_READ) begin
        reads++;
        if (ridx < DIST_BYTES) r.read_byte = dist_mem[ridx];
      end else begin
        if (wr_ptr >= BUF_DEPTH - 1) begin
          wr_ptr = 0;
          wraps++;
        end
        frame_mem[wr_ptr] = b;
        wr_ptr++;
        sync_count = (b == SYNC_BYTE) ? sync_count + 1 : 0;
        if (sync_count == SYNC_LEN) begin
          sync_count = 0;
          wr_ptr = RESYNC_IDX;
          resyncs++;
          for (int i = 0; i < SYNC_LEN; i++) frame_mem[i] = SYNC_BYTE;
        end
        if (header_synced()) begin
          if (mode == MODE_DIST && wr_ptr == DIST_AT) begin
            for (int i = 0; i < DIST_BYTES; i++) dist_mem[i] = frame_mem[DIST_FIRST + i];
            r.dist_done = 1'b1;
            dist_caps++;
          end else if (mode == MODE_COEF && wr_ptr == COEF_AT) begin
            for (int k = 0; k < COEF_NUM; k++) coef[k] = le_word(COEF_FIRST + 4 * k);
            points = le_half(PCOUNT_AT);
            coef_caps++;
          end else if (mode == MODE_RES && wr_ptr == RES_AT) begin
            width = le_half(RES_W_AT);
            height = le_half(RES_H_AT);
            params_ok = 1'b1;
            res_caps++;
          end
        end
      end
      r.coef = coef;
      r.points = points;
      r.width = width;
      r.height = height;
      r.params_ok = params_ok;
      results_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: result %0d, %s expected %0h, got %0h", $time, results, name, want,
                   got);
        end
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t want;
      if (results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: result arrived with none expected, read_byte %0h", $time,
                   got.read_byte);
        end
        return;
      end
      want = results_q.pop_front();
      results++;
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("distance_captured", want.dist_done, got.dist_done);
      for (int k = 0; k < COEF_NUM; k++) begin
        compare_field($sformatf("coefficient %0d", k), want.coef[k], got.coef[k]);
      end
      compare_field("point_count", want.points, got.points);
      compare_field("image_width", want.width, got.width);
      compare_field("image_height", want.height, got.height);
      compare_field("params_ready", want.params_ok, got.params_ok);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [7:0]        cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              operation_i;
  logic [7:0]        rx_byte_i;
  logic [RIDX_W-1:0] read_index_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [7:0]        read_byte_o;
  logic              distance_captured_o;
  logic [31:0]       coef_zero_o;
  logic [31:0]       coef_one_o;
  logic [31:0]       coef_two_o;
  logic [31:0]       coef_three_o;
  logic [15:0]       point_count_o;
  logic [15:0]       image_width_o;
  logic [15:0]       image_height_o;
  logic              params_ready_o;

  frame_scoreboard sb;
  parse_result_t   seen_result;
  bit              tx_gaps_on = 1'b1;
  bit              rx_gaps_on = 1'b1;
  bit              hold_done  = 1'b0;

  sync_word_lidar_frame_parser_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .operation_i         (operation_i),
    .rx_byte_i           (rx_byte_i),
    .read_index_i        (read_index_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .read_byte_o         (read_byte_o),
    .distance_captured_o (distance_captured_o),
    .coef_zero_o         (coef_zero_o),
    .coef_one_o          (coef_one_o),
    .coef_two_o          (coef_two_o),
    .coef_three_o        (coef_three_o),
    .point_count_o       (point_count_o),
    .image_width_o       (image_width_o),
    .image_height_o      (image_height_o),
    .params_ready_o      (params_ready_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.read_byte = read_byte_o;
      seen_result.dist_done = distance_captured_o;
      seen_result.coef[0]   = coef_zero_o;
      seen_result.coef[1]   = coef_one_o;
      seen_result.coef[2]   = coef_two_o;
      seen_result.coef[3]   = coef_three_o;
      seen_result.points    = point_count_o;
      seen_result.width     = image_width_o;
      seen_result.height    = image_height_o;
      seen_result.params_ok = params_ready_o;
      sb.check_result(seen_result);
    end
  end

  initial begin
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!hold_done && in_valid_i && sb.results >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_word(input logic op, input logic [7:0] b,
                           input logic [RIDX_W-1:0] ridx);
    int unsigned gap;
    gap = (tx_gaps_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    rx_byte_i    <= b;
    read_index_i <= ridx;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    sb.note_word(op, b, ridx);
  endtask

  task automatic send_read(input logic [RIDX_W-1:0] ridx);
    send_word(OP_READ, 8'($urandom_range(0, 255)), ridx);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) send_read(RIDX_W'($urandom_range(0, 511)));
    send_word(OP_RX, b, RIDX_W'($urandom_range(0, 511)));
  endtask

  task automatic send_frame(input int unsigned frame_len);
    int unsigned run;
    logic [7:0]  b;
    run = 0;
    repeat (SYNC_LEN) send_byte(SYNC_BYTE);
    for (int unsigned i = SYNC_LEN; i < frame_len; i++) begin
      b = ($urandom_range(0, 7) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255));
      run = (b == SYNC_BYTE) ? run + 1 : 0;
      if (run == SYNC_LEN || (i == frame_len - 1 && b == SYNC_BYTE)) begin
        b = FILLER_BYTE;
        run = 0;
      end
      send_byte(b);
    end
  endtask

  task automatic send_noise(input int unsigned n, input bit with_sync);
    logic [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (with_sync && $urandom_range(0, 2) == 0) b = SYNC_BYTE;
      if (b == SYNC_BYTE && (!with_sync || i == n - 1)) b = FILLER_BYTE;
      send_byte(b);
    end
  endtask

  task automatic send_frames(input int unsigned cap);
    repeat ($urandom_range(3, 5)) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat (SYNC_LEN - 1) send_byte(SYNC_BYTE);
          send_byte(FILLER_BYTE);
        end
        1: send_frame($urandom_range(SYNC_LEN + 1, cap - 1));
        default: begin
          send_frame(cap);
          send_noise($urandom_range(0, 3), 1'b0);
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [7:0] m);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    sb.set_mode(m);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] m);
    wait_idle();
    write_mode(m);
    tx_gaps_on = ($urandom_range(0, 3) != 0);
    rx_gaps_on = ($urandom_range(0, 3) != 0);
    case (m)
      MODE_DIST: begin
        send_frame(DIST_AT);
        repeat (10) send_read(RIDX_W'($urandom_range(0, DIST_BYTES - 1)));
        // Enough plain bytes after the frame to carry the index past the wrap point.
        send_noise(70, 1'b0);
      end
      MODE_COEF: send_frames(COEF_AT);
      MODE_RES:  send_frames(RES_AT);
      default: begin
        send_noise(30, 1'b1);
        send_frame(RES_AT);
        send_frame(COEF_AT);
        send_noise(10, 1'b1);
      end
    endcase
  endtask

  initial begin
    logic [7:0] res_bytes [10];
    logic [7:0] plan [8];
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_RX;
    rx_byte_i    = '0;
    read_index_i = '0;
    sb = new();
    res_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h80, 8'hFF, 8'hFF, 8'h00, 8'h00};
    plan = '{MODE_COEF, MODE_DIST, 8'hFF, MODE_RES, 8'($urandom_range(0, 255)), 8'h00,
             MODE_COEF, MODE_RES};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_mode(MODE_RES);
    send_word(OP_READ, 8'hFF, '0);
    send_word(OP_READ, 8'h00, RIDX_W'(DIST_BYTES - 1));
    send_word(OP_READ, 8'h00, RIDX_W'(DIST_BYTES));
    send_word(OP_READ, 8'hFF, '1);
    // A sync run broken after three bytes must not move the index.
    repeat (SYNC_LEN - 1) send_word(OP_RX, SYNC_BYTE, '1);
    send_word(OP_RX, 8'h00, '0);
    // Resolution frame with all-ones width and all-zeros height.
    repeat (SYNC_LEN) send_word(OP_RX, SYNC_BYTE, '0);
    foreach (res_bytes[i]) send_word(OP_RX, res_bytes[i], '1);

    foreach (plan[p]) begin
      if (sb.words < ITEM_TARGET) run_phase(plan[p]);
    end

    wait_idle();
    write_mode(MODE_COEF);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_frame(COEF_AT);
    repeat (10) send_read(RIDX_W'($urandom_range(0, 511)));
    send_frame(COEF_AT);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d words (%0d reads) over %0d mode writes: %0d distance, %0d coefficient",
             sb.words, sb.reads, sb.mode_writes, sb.dist_caps, sb.coef_caps);
    $display("and %0d resolution frames, %0d index wraps, %0d resyncs; %0d fields disagreed.",
             sb.res_caps, sb.wraps, sb.resyncs, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
